>>> design/tmhq_pkg.sv
// Shared types and constants for the ternary min-heap queue.
package tmhq_pkg;

  localparam int KeyW   = 32;
  localparam int IdxW   = 10;
  localparam int CountW = 11;

  typedef enum logic [1:0] {
    MODE_INSERT   = 2'd0,
    MODE_DECREASE = 2'd1,
    MODE_EXTRACT  = 2'd2,
    MODE_NONE     = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2,
    STATUS_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    mode_e                  mode;
    logic signed [KeyW-1:0] key;
    logic [IdxW-1:0]        index;
  } in_word_t;

  typedef struct packed {
    logic signed [KeyW-1:0] min_key;
    logic [CountW-1:0]      count;
    status_e                status;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_UP_CHECK,
    ST_UP_DIV,
    ST_UP_CMP,
    ST_EX_LAST,
    ST_EX_LOAD,
    ST_DN_CHECK,
    ST_DN_C1,
    ST_DN_C2,
    ST_DN_C3,
    ST_DN_MOVE,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    POS_HOLD,
    POS_FILL,
    POS_INDEX,
    POS_ZERO,
    POS_PARENT,
    POS_BEST
  } pos_sel_e;

  typedef enum logic [1:0] {
    KEY_HOLD,
    KEY_INPUT,
    KEY_RDATA
  } key_sel_e;

  typedef enum logic [2:0] {
    RD_ROOT,
    RD_LAST,
    RD_PARENT,
    RD_C1,
    RD_C2,
    RD_C3
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_KEY,
    WR_RDATA,
    WR_BEST
  } wr_sel_e;

  typedef struct packed {
    logic     cap_in;
    logic     status_we;
    status_e  status;
    logic     clr_min;
    logic     cap_min;
    logic     fill_inc;
    logic     fill_dec;
    pos_sel_e pos_sel;
    key_sel_e key_sel;
    logic     rd_en;
    rd_sel_e  rd_sel;
    logic     wr_en;
    wr_sel_e  wr_sel;
    logic     mul_start;
    logic     par_cap;
    logic     best_init;
    logic     best_upd;
    logic     load_out;
  } dp_cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  full;
    logic  empty;
    logic  bad_index;
    logic  pos_zero;
    logic  child_out;
    logic  k_lt_rd;
    logic  k_gt_best;
  } dp_status_t;

endpackage

>>> design/tmhq_ctrl.sv
// Sequencer for insert, decrease-key and extract-min on the heap datapath.
module tmhq_ctrl
  import tmhq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t sts_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (sts_i.mode)
          MODE_INSERT:   state_d = sts_i.full ? ST_DONE : ST_UP_CHECK;
          MODE_DECREASE: state_d = sts_i.bad_index ? ST_DONE : ST_UP_CHECK;
          MODE_EXTRACT:  state_d = sts_i.empty ? ST_DONE : ST_EX_LAST;
          default:       state_d = ST_DONE;
        endcase
      end
      ST_UP_CHECK: state_d = sts_i.pos_zero ? ST_DONE : ST_UP_DIV;
      ST_UP_DIV:   state_d = ST_UP_CMP;
      ST_UP_CMP:   state_d = sts_i.k_lt_rd ? ST_UP_CHECK : ST_DONE;
      ST_EX_LAST:  state_d = ST_EX_LOAD;
      ST_EX_LOAD:  state_d = ST_DN_CHECK;
      ST_DN_CHECK: state_d = sts_i.child_out ? ST_DONE : ST_DN_C1;
      ST_DN_C1:    state_d = ST_DN_C2;
      ST_DN_C2:    state_d = ST_DN_C3;
      ST_DN_C3:    state_d = ST_DN_MOVE;
      ST_DN_MOVE:  state_d = sts_i.k_gt_best ? ST_DN_CHECK : ST_DONE;
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.cap_in = in_valid_i;
      end
      ST_DECODE: begin
        cmd_o.status_we = 1'b1;
        cmd_o.status    = STATUS_OK;
        cmd_o.clr_min   = 1'b1;
        unique case (sts_i.mode)
          MODE_INSERT: begin
            if (sts_i.full) begin
              cmd_o.status = STATUS_FULL;
            end else begin
              cmd_o.pos_sel  = POS_FILL;
              cmd_o.key_sel  = KEY_INPUT;
              cmd_o.fill_inc = 1'b1;
            end
          end
          MODE_DECREASE: begin
            if (sts_i.bad_index) begin
              cmd_o.status = STATUS_RANGE;
            end else begin
              cmd_o.pos_sel = POS_INDEX;
              cmd_o.key_sel = KEY_INPUT;
            end
          end
          MODE_EXTRACT: begin
            if (sts_i.empty) begin
              cmd_o.status = STATUS_EMPTY;
            end else begin
              cmd_o.rd_en    = 1'b1;
              cmd_o.rd_sel   = RD_ROOT;
              cmd_o.fill_dec = 1'b1;
            end
          end
          default: ;
        endcase
      end
      ST_UP_CHECK: begin
        if (sts_i.pos_zero) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = WR_KEY;
        end else begin
          cmd_o.mul_start = 1'b1;
        end
      end
      ST_UP_DIV: begin
        cmd_o.par_cap = 1'b1;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = RD_PARENT;
      end
      ST_UP_CMP: begin
        cmd_o.wr_en = 1'b1;
        if (sts_i.k_lt_rd) begin
          cmd_o.wr_sel  = WR_RDATA;
          cmd_o.pos_sel = POS_PARENT;
        end else begin
          cmd_o.wr_sel = WR_KEY;
        end
      end
      ST_EX_LAST: begin
        cmd_o.cap_min = 1'b1;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = RD_LAST;
      end
      ST_EX_LOAD: begin
        cmd_o.key_sel = KEY_RDATA;
        cmd_o.pos_sel = POS_ZERO;
      end
      ST_DN_CHECK: begin
        if (sts_i.child_out) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = WR_KEY;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_C1;
        end
      end
      ST_DN_C1: begin
        cmd_o.best_init = 1'b1;
        cmd_o.rd_en     = 1'b1;
        cmd_o.rd_sel    = RD_C2;
      end
      ST_DN_C2: begin
        cmd_o.best_upd = 1'b1;
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_sel   = RD_C3;
      end
      ST_DN_C3: begin
        cmd_o.best_upd = 1'b1;
      end
      ST_DN_MOVE: begin
        cmd_o.wr_en = 1'b1;
        if (sts_i.k_gt_best) begin
          cmd_o.wr_sel  = WR_BEST;
          cmd_o.pos_sel = POS_BEST;
        end else begin
          cmd_o.wr_sel = WR_KEY;
        end
      end
      ST_DONE: begin
        cmd_o.load_out = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> design/tmhq_dp.sv
// Heap datapath: key memory, position and key registers, parent divider, result register.
module tmhq_dp
  import tmhq_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_word_t   in_word_i,
  input  dp_cmd_t    cmd_i,
  output dp_status_t sts_o,
  output out_word_t  out_word_o
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int PW    = AW + 2;
  localparam int CmpW  = (CW > IdxW) ? CW : IdxW;
  localparam int CntW  = (CW > CountW) ? CW : CountW;
  localparam int RecW  = AW + 1;
  localparam int ProdW = AW + RecW;
  localparam logic [RecW-1:0] Recip = RecW'((2 ** RecW) / 3);

  logic signed [KeyW-1:0] mem [CAPACITY];

  in_word_t               in_q;
  logic [CW-1:0]          fill_q;
  logic [AW-1:0]          pos_q, par_q, best_idx_q, rd_addr_q;
  logic signed [KeyW-1:0] k_q, best_val_q, rdata_q, min_q;
  logic [ProdW-1:0]       prod_q;
  status_e                status_q;
  out_word_t              out_q;

  // Parent of pos: (pos-1)/3 by reciprocal, then one correction step.
  logic [AW-1:0] pm1, q0, parent;
  logic [PW-1:0] rem;
  assign pm1    = pos_q - AW'(1);
  assign q0     = prod_q[ProdW-1:RecW];
  assign rem    = PW'(pm1) - (PW'(q0) << 1) - PW'(q0);
  assign parent = (rem >= PW'(3)) ? q0 + AW'(1) : q0;

  // Children of pos, the second and third clamped to the last entry.
  logic [PW-1:0] fill_p, c1, c2, c3, c2c, c3c;
  assign fill_p = PW'(fill_q);
  assign c1     = (PW'(pos_q) << 1) + PW'(pos_q) + PW'(1);
  assign c2     = c1 + PW'(1);
  assign c3     = c1 + PW'(2);
  assign c2c    = (c2 >= fill_p) ? fill_p - PW'(1) : c2;
  assign c3c    = (c3 >= fill_p) ? fill_p - PW'(1) : c3;

  logic [CmpW-1:0] idx_ext;
  assign idx_ext = CmpW'(in_q.index);

  logic [AW-1:0] rd_addr;
  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_ROOT:   rd_addr = '0;
      RD_LAST:   rd_addr = fill_q[AW-1:0];
      RD_PARENT: rd_addr = parent;
      RD_C1:     rd_addr = c1[AW-1:0];
      RD_C2:     rd_addr = c2c[AW-1:0];
      RD_C3:     rd_addr = c3c[AW-1:0];
      default:   rd_addr = '0;
    endcase
  end

  logic signed [KeyW-1:0] wdata;
  always_comb begin
    unique case (cmd_i.wr_sel)
      WR_KEY:   wdata = k_q;
      WR_RDATA: wdata = rdata_q;
      WR_BEST:  wdata = best_val_q;
      default:  wdata = k_q;
    endcase
  end

  logic [AW-1:0] pos_d;
  always_comb begin
    unique case (cmd_i.pos_sel)
      POS_HOLD:   pos_d = pos_q;
      POS_FILL:   pos_d = fill_q[AW-1:0];
      POS_INDEX:  pos_d = idx_ext[AW-1:0];
      POS_ZERO:   pos_d = '0;
      POS_PARENT: pos_d = par_q;
      POS_BEST:   pos_d = best_idx_q;
      default:    pos_d = pos_q;
    endcase
  end

  logic signed [KeyW-1:0] k_d;
  always_comb begin
    unique case (cmd_i.key_sel)
      KEY_HOLD:  k_d = k_q;
      KEY_INPUT: k_d = in_q.key;
      KEY_RDATA: k_d = rdata_q;
      default:   k_d = k_q;
    endcase
  end

  logic [CntW-1:0] cnt_ext;
  assign cnt_ext = CntW'(fill_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) mem[pos_q] <= wdata;
    if (cmd_i.rd_en) begin
      rdata_q   <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in)    in_q <= in_word_i;
    pos_q <= pos_d;
    k_q   <= k_d;
    if (cmd_i.mul_start) prod_q <= ProdW'(pm1) * ProdW'(Recip);
    if (cmd_i.par_cap)   par_q <= parent;
    if (cmd_i.best_init) begin
      best_val_q <= rdata_q;
      best_idx_q <= rd_addr_q;
    end else if (cmd_i.best_upd && (rdata_q < best_val_q)) begin
      best_val_q <= rdata_q;
      best_idx_q <= rd_addr_q;
    end
    if (cmd_i.status_we) status_q <= cmd_i.status;
    if (cmd_i.clr_min) begin
      min_q <= '0;
    end else if (cmd_i.cap_min) begin
      min_q <= rdata_q;
    end
    if (cmd_i.load_out) begin
      out_q.min_key <= min_q;
      out_q.count   <= cnt_ext[CountW-1:0];
      out_q.status  <= status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (cmd_i.fill_inc) begin
      fill_q <= fill_q + CW'(1);
    end else if (cmd_i.fill_dec) begin
      fill_q <= fill_q - CW'(1);
    end
  end

  assign sts_o.mode      = in_q.mode;
  assign sts_o.full      = (fill_q == CW'(CAPACITY));
  assign sts_o.empty     = (fill_q == '0);
  assign sts_o.bad_index = (idx_ext >= CmpW'(fill_q));
  assign sts_o.pos_zero  = (pos_q == '0);
  assign sts_o.child_out = (c1 >= fill_p);
  assign sts_o.k_lt_rd   = (k_q < rdata_q);
  assign sts_o.k_gt_best = (k_q > best_val_q);

  assign out_word_o = out_q;

endmodule

>>> design/ternary_min_heap_queue_top.sv
// Top level of the ternary min-heap priority queue.
//
//  channel | direction | handshake                  | word
//  --------+-----------+----------------------------+----------------------------
//  in      | input     | in_valid_i / in_ready_o    | in_word_i  (mode, key, index)
//  out     | output    | out_valid_o / out_ready_i  | out_word_o (min_key, count, status)
//
// One word in, one word out; words are processed one at a time.
// Errors and mode 3 go straight to the result without touching the heap.
// Insert and decrease-key climb one level at a time (parent divide-by-3
// multiply, memory read, compare and write back).
// Extract-min descends one level at a time (three child reads on the
// single memory read port, best-child select, move).
// Reset clears the fill count and the handshake state; the key memory is
// not cleared, since only entries below the fill count are ever read.
// A new word is taken while a finished result still waits in the output
// register; the block stalls only when a second result is ready.
module ternary_min_heap_queue_top
  import tmhq_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  dp_cmd_t    cmd;
  dp_status_t sts;

  // Sequencer: walks the heap one level at a time.
  tmhq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Key memory, sift registers and result register.
  tmhq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_word_o (out_word_o)
  );

endmodule

>>> tb/sv/ternary_min_heap_queue_top_tb.sv
// Testbench for the ternary min-heap queue: directed table, random traffic, scoreboard.
`timescale 1ns / 1ps

module ternary_min_heap_queue_top_tb
  import tmhq_pkg::*;
();

  localparam int HeapDepth = 1024;
  localparam int HoldLen   = 300;   // receiver hold-off, in cycles
  localparam int DrainWait = 64;    // idle wait after the last drain, before the verdict

  // One row of the directed table. When typed is set, want is the result
  // word read straight off the spec; otherwise the predictor supplies it.
  typedef struct packed {
    in_word_t  w;
    logic      typed;
    out_word_t want;
  } drill_row_t;

  // Every DUT input has a known value from time zero.
  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  in_word_t  in_word   = '0;
  logic      out_ready = 1'b0;
  logic      in_ready_o;
  logic      out_valid_o;
  out_word_t out_word_o;

  // Typed expectation rides along with the word, updated by NBA in the same
  // step as the word itself, so the scoreboard sees the matching pair.
  logic      row_typed = 1'b0;
  out_word_t row_want  = '0;

  // Predictor state: own copy of the heap.
  logic signed [KeyW-1:0] heap_keys [HeapDepth];
  int unsigned            heap_fill = 0;

  out_word_t   owed_results [$];
  drill_row_t  drill_rows [$];
  int          mismatches   = 0;
  int unsigned shadow_fill  = 0;   // sender-side estimate of the fill, for shaping only
  int unsigned send_idle    = 0;   // percent chance of an idle cycle before each word
  int unsigned stall_pct    = 0;   // percent chance of ready low on a cycle
  int unsigned hold_asked   = 0;   // bumped by the stimulus to request a hold-off
  int unsigned hold_started = 0;
  int unsigned hold_left    = 0;

  ternary_min_heap_queue_top #(
    .CAPACITY(HeapDepth)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_word_o (out_word_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Sift a key toward the root while it beats its parent (p-1)/3.
  function automatic void heap_rise(input int unsigned start);
    int unsigned            pos;
    int unsigned            up;
    logic signed [KeyW-1:0] t;
    logic                   moving;
    pos    = start;
    moving = 1'b1;
    while (moving && pos > 0) begin
      up = (pos - 1) / 3;
      if (heap_keys[pos] < heap_keys[up]) begin
        t              = heap_keys[pos];
        heap_keys[pos] = heap_keys[up];
        heap_keys[up]  = t;
        pos            = up;
      end else begin
        moving = 1'b0;
      end
    end
  endfunction

  // Apply one word to the predicted heap and return the result word it owes.
  function automatic out_word_t heap_result(input in_word_t w);
    out_word_t              r;
    int unsigned            pos;
    int unsigned            best;
    int unsigned            c;
    int unsigned            n;
    logic signed [KeyW-1:0] t;
    logic                   moving;
    r        = '0;
    r.status = STATUS_OK;
    case (w.mode)
      MODE_INSERT: begin
        if (heap_fill >= HeapDepth) begin
          r.status = STATUS_FULL;
        end else begin
          heap_keys[heap_fill] = w.key;
          heap_fill++;
          heap_rise(heap_fill - 1);
        end
      end
      MODE_DECREASE: begin
        // no check that the new key is smaller; it only ever climbs
        if (w.index >= heap_fill) begin
          r.status = STATUS_RANGE;
        end else begin
          heap_keys[w.index] = w.key;
          heap_rise(w.index);
        end
      end
      MODE_EXTRACT: begin
        if (heap_fill == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.min_key    = heap_keys[0];
          heap_fill--;
          heap_keys[0] = heap_keys[heap_fill];
          n            = heap_fill;
          pos          = 0;
          moving       = 1'b1;
          // sift down past the smallest child; missing children clamp to the last entry,
          // and the first child wins ties
          while (moving && 3 * pos + 1 < n) begin
            best = 3 * pos + 1;
            for (int k = 2; k <= 3; k++) begin
              c = 3 * pos + k;
              if (c > n - 1) c = n - 1;
              if (heap_keys[c] < heap_keys[best]) best = c;
            end
            if (heap_keys[pos] > heap_keys[best]) begin
              t               = heap_keys[pos];
              heap_keys[pos]  = heap_keys[best];
              heap_keys[best] = t;
              pos             = best;
            end else begin
              moving = 1'b0;
            end
          end
        end
      end
      default: ;  // unused mode: no change at all
    endcase
    r.count = CountW'(heap_fill);
    return r;
  endfunction

  // Scoreboard: predict on every accepted input word, check every accepted output word.
  always @(posedge clk_i) begin : scoreboard
    out_word_t predicted;
    out_word_t want;
    if (rst_ni) begin
      if (in_valid && in_ready_o) begin
        predicted = heap_result(in_word);
        owed_results.push_back(row_typed ? row_want : predicted);
      end
      if (out_valid_o && out_ready) begin
        if (owed_results.size() == 0) begin
          $display("%0t: result word with nothing owed: min_key %0d count %0d status %0d",
                   $time, out_word_o.min_key, out_word_o.count, out_word_o.status);
          mismatches++;
        end else begin
          want = owed_results.pop_front();
          if (out_word_o.min_key !== want.min_key) begin
            $display("%0t: min_key expected %0d got %0d", $time, want.min_key,
                     out_word_o.min_key);
            mismatches++;
          end
          if (out_word_o.count !== want.count) begin
            $display("%0t: count expected %0d got %0d", $time, want.count, out_word_o.count);
            mismatches++;
          end
          if (out_word_o.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status,
                     out_word_o.status);
            mismatches++;
          end
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off counted here when asked for.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_started != hold_asked) begin
      out_ready    <= 1'b0;
      hold_left    <= HoldLen;
      hold_started <= hold_started + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic void add_row(input mode_e m, input logic signed [KeyW-1:0] k,
                                  input logic [IdxW-1:0] ix, input logic typed,
                                  input logic signed [KeyW-1:0] mk,
                                  input logic [CountW-1:0] cnt, input status_e st);
    drill_row_t row;
    row.w.mode       = m;
    row.w.key        = k;
    row.w.index      = ix;
    row.typed        = typed;
    row.want.min_key = mk;
    row.want.count   = cnt;
    row.want.status  = st;
    drill_rows.push_back(row);
  endfunction

  // Keys: extremes, a narrow band around zero for ties, and full-range values.
  function automatic logic signed [KeyW-1:0] pick_key();
    case ($urandom_range(9))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2, 3, 4: return int'($urandom_range(16)) - 8;
      default: return $urandom;
    endcase
  endfunction

  // Random word, leaning the fill toward fill_goal. Decrease mostly hits a
  // live position, sometimes anywhere in the 10-bit index range.
  function automatic in_word_t next_word(input int unsigned fill_goal);
    in_word_t    w;
    int unsigned roll;
    w.key   = pick_key();
    w.index = IdxW'($urandom);
    roll    = $urandom_range(99);
    if (roll < 3) begin
      w.mode = MODE_NONE;
    end else if (roll < 20) begin
      w.mode = MODE_DECREASE;
      if (shadow_fill != 0 && $urandom_range(9) != 0)
        w.index = IdxW'($urandom_range(shadow_fill - 1));
    end else if (roll < ((shadow_fill < fill_goal) ? 75 : 45)) begin
      w.mode = MODE_INSERT;
    end else begin
      w.mode = MODE_EXTRACT;
    end
    return w;
  endfunction

  // Offer one word, with random idle cycles ahead of it, and hold it until taken.
  task automatic send_word(input in_word_t w, input logic typed, input out_word_t want);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    in_word   <= w;
    row_typed <= typed;
    row_want  <= want;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (w.mode == MODE_INSERT && shadow_fill < HeapDepth) shadow_fill++;
    if (w.mode == MODE_EXTRACT && shadow_fill != 0) shadow_fill--;
  endtask

  // Sender pauses until every owed result word has come back.
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (owed_results.size() != 0);
  endtask

  initial begin : stimulus
    int unsigned idle_by_phase  [4];
    int unsigned stall_by_phase [4];
    int unsigned goal;
    in_word_t    w;
    idle_by_phase  = '{0, 64, 0, 22};
    stall_by_phase = '{0, 0, 64, 22};

    // Directed table. Expected words are typed in where they are obvious:
    // empty-heap extract, bad index, the unused mode, plain inserts and the
    // fill count that follows. Extracts after the heap is disturbed go to the
    // predictor.
    add_row(MODE_EXTRACT,  0,             0,    1, 0, 0, STATUS_EMPTY);
    add_row(MODE_DECREASE, -5,            0,    1, 0, 0, STATUS_RANGE);
    add_row(MODE_NONE,     -1,            1023, 1, 0, 0, STATUS_OK);
    add_row(MODE_INSERT,   32'sh7fffffff, 0,    1, 0, 1, STATUS_OK);
    add_row(MODE_INSERT,   32'sh80000000, 0,    1, 0, 2, STATUS_OK);
    add_row(MODE_INSERT,   0,             0,    1, 0, 3, STATUS_OK);
    add_row(MODE_INSERT,   -1,            0,    1, 0, 4, STATUS_OK);
    add_row(MODE_INSERT,   5,             0,    1, 0, 5, STATUS_OK);
    add_row(MODE_INSERT,   5,             0,    1, 0, 6, STATUS_OK);
    add_row(MODE_INSERT,   3,             0,    1, 0, 7, STATUS_OK);
    add_row(MODE_DECREASE, 0,             1023, 1, 0, 7, STATUS_RANGE);
    add_row(MODE_DECREASE, 0,             7,    1, 0, 7, STATUS_RANGE);  // first bad index
    add_row(MODE_DECREASE, -7,            6,    1, 0, 7, STATUS_OK);
    // raise the root: decrease never sifts down, so the heap is left out of order
    add_row(MODE_DECREASE, 32'sh7fffffff, 0,    1, 0, 7, STATUS_OK);
    add_row(MODE_EXTRACT,  0,             0,    0, 0, 0, STATUS_OK);
    add_row(MODE_EXTRACT,  0,             0,    0, 0, 0, STATUS_OK);
    add_row(MODE_NONE,     0,             0,    1, 0, 5, STATUS_OK);
    for (int i = 0; i < 5; i++) add_row(MODE_EXTRACT, 0, 0, 0, 0, 0, STATUS_OK);
    add_row(MODE_EXTRACT,  0,             0,    1, 0, 0, STATUS_EMPTY);
    add_row(MODE_INSERT,   32'sh80000000, 0,    1, 0, 1, STATUS_OK);
    add_row(MODE_EXTRACT,  0,             0,    1, 32'sh80000000, 0, STATUS_OK);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (drill_rows[i]) send_word(drill_rows[i].w, drill_rows[i].typed, drill_rows[i].want);
    wait_drain();

    // Random traffic in four idling phases; the target size moves every 20 words
    // and stays small so most extracts walk a few levels.
    goal = 8;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = idle_by_phase[ph];
      stall_pct = stall_by_phase[ph];
      for (int n = 0; n < 40; n++) begin
        if (n % 20 == 0) goal = $urandom_range(64, 2);
        send_word(next_word(goal), 1'b0, '0);
      end
      wait_drain();
    end

    // Back-pressure: receiver holds off while the sender keeps offering words,
    // so the output register fills and the input stalls.
    send_idle = 0;
    stall_pct = 0;
    hold_asked++;
    for (int n = 0; n < 30; n++) send_word(next_word(32), 1'b0, '0);
    wait_drain();

    // Fill to capacity, push into a full heap, decrease at the top index,
    // then mixed traffic at full depth.
    send_idle = 22;
    stall_pct = 22;
    while (shadow_fill < HeapDepth) begin
      w.mode  = MODE_INSERT;
      w.key   = pick_key();
      w.index = IdxW'($urandom);
      send_word(w, 1'b0, '0);
    end
    for (int n = 0; n < 3; n++) begin
      w.mode = MODE_INSERT;
      w.key  = pick_key();
      send_word(w, 1'b1, '{min_key: '0, count: CountW'(HeapDepth), status: STATUS_FULL});
    end
    w.mode  = MODE_DECREASE;
    w.key   = 32'sh80000000;
    w.index = IdxW'(HeapDepth - 1);
    send_word(w, 1'b0, '0);
    for (int n = 0; n < 30; n++) send_word(next_word(HeapDepth), 1'b0, '0);
    wait_drain();

    // Let anything stray show up before the verdict.
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (about 1250 words).
  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
